/* hdl/itaf_pkg.sv */
// Shared types, constants and the digit-to-character function for the
// integer-to-ASCII formatter. No dependencies.
package itaf_pkg;

  // Default width of the converted number.
  localparam int VALUE_WIDTH_DEF = 32;

  // Widths of the result fields.
  localparam int CHAR_W  = 7;
  localparam int COUNT_W = 31;

  // Saturation point of the running character count.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // ASCII codes used to build the text.
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_LOW_A = 7'h61;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 7'h41;

  // Output formats selected by the opcode of an item.
  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_HEXL = 2'd2,
    OP_HEXU = 2'd3
  } opcode_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_t;

  // Maps one digit to its ASCII code; letters come in the requested case.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_UP_A : CH_LOW_A;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + CHAR_W'(d);
    end else begin
      digit_char = base + CHAR_W'(d - 4'd10);
    end
  endfunction

endpackage

/* hdl/integer_to_ascii_formatter_core.sv */
// Integer-to-ASCII formatter: converts one number per item to decimal or hex
// text and streams it out one character per result item. Uses itaf_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) carries an opcode and a value. The
//   opcode picks signed decimal, unsigned decimal, lower-case or upper-case hex.
//   The output channel (out_valid/out_ready) carries one ASCII character per
//   item, most significant digit first, with last_char set on the final one
//   and total_chars giving the saturating count of characters emitted so far.
//   Decimal items run a shift-add-3 converter one input bit per cycle; hex
//   items skip this step. Leading zero digits are then dropped one per cycle,
//   and characters follow one per cycle while the receiver is ready, so each
//   dropped zero is one character less to send. A negative signed decimal
//   item sends a minus sign before its digits.
//   A new item is taken once the last character of the previous one sits in
//   the output register. A stalled receiver holds the output register and the
//   sequencer waits. Reset empties the block and clears the character count.
module integer_to_ascii_formatter_core #(
  parameter int VALUE_WIDTH = itaf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [VALUE_WIDTH-1:0]        value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itaf_pkg::CHAR_W-1:0]   char_code,
  output logic                          last_char,
  output logic [itaf_pkg::COUNT_W-1:0]  total_chars
);
  import itaf_pkg::*;

  // Decimal digits needed for the largest value, hex digits, and the wider.
  localparam int NDEC = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NHEX = (VALUE_WIDTH + 3) / 4;
  localparam int ND   = (NDEC > NHEX) ? NDEC : NHEX;
  localparam int DW   = 4 * ND;
  localparam int CW   = $clog2(ND + 1);
  localparam int BW   = $clog2(VALUE_WIDTH);

  state_t                 state, state_next;
  logic [VALUE_WIDTH-1:0] bin, bin_next;
  logic [DW-1:0]          digs, digs_next;
  logic [DW-1:0]          digs_adj;
  logic [CW-1:0]          cnt, cnt_next;
  logic [BW-1:0]          bitcnt, bitcnt_next;
  logic                   minus, minus_next;
  logic                   upper, upper_next;
  logic                   out_valid_next;
  logic [CHAR_W-1:0]      char_code_next;
  logic                   last_char_next;
  logic [COUNT_W-1:0]     total_chars_next;
  logic                   in_fire;
  logic                   slot_free;
  logic                   load_char;
  logic                   is_neg;
  logic [VALUE_WIDTH-1:0] mag;
  logic [3:0]             top_digit;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign load_char = (state == S_EMIT) && slot_free;
  assign top_digit = digs[DW-1 -: 4];

  // Magnitude of the input; only signed decimal can be negative.
  assign is_neg = (opcode == OP_SDEC) && value[VALUE_WIDTH-1];
  assign mag    = is_neg ? VALUE_WIDTH'(~value + 1'b1) : value;

  // Add-3 correction of every BCD digit that is five or more.
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      digs_adj[4*i +: 4] = (digs[4*i +: 4] >= 4'd5) ? digs[4*i +: 4] + 4'd3
                                                    : digs[4*i +: 4];
    end
  end

  // Sequencer: next state, datapath loads and the output register.
  always_comb begin
    state_next       = state;
    bin_next         = bin;
    digs_next        = digs;
    cnt_next         = cnt;
    bitcnt_next      = bitcnt;
    minus_next       = minus;
    upper_next       = upper;
    out_valid_next   = out_valid && !out_ready;
    char_code_next   = char_code;
    last_char_next   = last_char;
    total_chars_next = total_chars;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          minus_next  = is_neg;
          upper_next  = (opcode == OP_HEXU);
          cnt_next    = CW'(ND);
          bitcnt_next = '0;
          if (opcode inside {OP_HEXL, OP_HEXU}) begin
            digs_next  = {{(DW - VALUE_WIDTH){1'b0}}, value};
            state_next = S_SKIP;
          end else begin
            digs_next  = '0;
            bin_next   = mag;
            state_next = S_CONV;
          end
        end
      end
      S_CONV: begin
        // One input bit enters the BCD register each cycle.
        digs_next   = {digs_adj[DW-2:0], bin[VALUE_WIDTH-1]};
        bin_next    = {bin[VALUE_WIDTH-2:0], 1'b0};
        bitcnt_next = bitcnt + 1'b1;
        if (bitcnt == BW'(VALUE_WIDTH - 1)) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        // Drop leading zeros, keeping at least one digit.
        if ((top_digit == 4'd0) && (cnt != CW'(1))) begin
          digs_next = {digs[DW-5:0], 4'd0};
          cnt_next  = cnt - 1'b1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load_char) begin
          out_valid_next   = 1'b1;
          total_chars_next = (total_chars == COUNT_MAX) ? total_chars
                                                        : total_chars + 1'b1;
          if (minus) begin
            char_code_next = CH_MINUS;
            last_char_next = 1'b0;
            minus_next     = 1'b0;
          end else begin
            char_code_next = digit_char(top_digit, upper);
            last_char_next = (cnt == CW'(1));
            digs_next      = {digs[DW-5:0], 4'd0};
            cnt_next       = cnt - 1'b1;
            if (cnt == CW'(1)) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      total_chars <= '0;
    end else begin
      state       <= state_next;
      out_valid   <= out_valid_next;
      total_chars <= total_chars_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    bin       <= bin_next;
    digs      <= digs_next;
    cnt       <= cnt_next;
    bitcnt    <= bitcnt_next;
    minus     <= minus_next;
    upper     <= upper_next;
    char_code <= char_code_next;
    last_char <= last_char_next;
  end

`ifndef ASSERT_OFF
  // Every loaded character advances the count by one unless it is saturated.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    load_char |=> (total_chars == $past(total_chars) + 1'b1) ||
                  (total_chars == COUNT_MAX))
    else $error("character count did not advance on a loaded character");

  // Digit stages never run with an empty digit counter.
  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SKIP) || (state == S_EMIT)) |-> (cnt != '0))
    else $error("digit counter empty while digits remain to be sent");

  // The converter stops after the last input bit.
  a_conv_end: assert property (@(posedge clk) disable iff (rst)
    ((state == S_CONV) && (bitcnt == BW'(VALUE_WIDTH - 1))) |=> (state == S_SKIP))
    else $error("conversion did not end after the last bit");

  // The final character of an item frees the input side.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (load_char && last_char_next) |=> (state == S_IDLE) && out_valid && last_char)
    else $error("last character did not return the block to idle");
`endif

endmodule

/* bench/tb_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the integer-to-ASCII formatter: watches both channels,
// predicts the character stream of each accepted number and compares it.
// Depends on itaf_pkg for the opcode enum, field widths and ASCII codes.
module tb_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic [31:0]                  value,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [itaf_pkg::CHAR_W-1:0]  char_code,
  input  logic                         last_char,
  input  logic [itaf_pkg::COUNT_W-1:0] total_chars,
  output int                           fail_count,
  output int                           chars_left,
  output int                           chars_seen
);
  import itaf_pkg::*;

  // One expected output character with its end marker and running count.
  typedef struct packed {
    logic [CHAR_W-1:0]  code;
    logic               is_last;
    logic [COUNT_W-1:0] count;
  } char_rec_t;

  localparam int REPORT_LIMIT = 10;

  string LOWER_DIGITS = "0123456789abcdef";
  string UPPER_DIGITS = "0123456789ABCDEF";

  char_rec_t          pending_chars[$];
  logic [COUNT_W-1:0] char_count;

  // Builds the text of one number and queues its characters in order.
  task automatic render_number(input opcode_t op, input logic [31:0] raw);
    logic [63:0]       mag;
    logic [CHAR_W-1:0] text[$];
    logic [CHAR_W-1:0] digits[$];
    logic [7:0]        glyph;
    logic [3:0]        nib;
    char_rec_t         rec;
    mag = {32'd0, raw};
    text = {};
    digits = {};
    // Negative signed numbers print a minus and then the magnitude; the
    // most negative value wraps to its own bit pattern, which is correct.
    if (op == OP_SDEC && raw[31]) begin
      text.push_back(CH_MINUS);
      mag = {32'd0, ~raw + 32'd1};
    end
    if (op == OP_SDEC || op == OP_UDEC) begin
      do begin
        digits.push_front(CH_ZERO + CHAR_W'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 64'd0);
    end else begin
      do begin
        nib = mag[3:0];
        glyph = (op == OP_HEXU) ? UPPER_DIGITS[nib] : LOWER_DIGITS[nib];
        digits.push_front(glyph[CHAR_W-1:0]);
        mag = mag >> 4;
      end while (mag != 64'd0);
    end
    foreach (digits[k]) text.push_back(digits[k]);
    foreach (text[k]) begin
      if (char_count != COUNT_MAX) char_count = char_count + 1'b1;
      rec.code = text[k];
      rec.is_last = (k == text.size() - 1);
      rec.count = char_count;
      pending_chars.push_back(rec);
    end
  endtask

  // Predict on each accepted number, compare on each accepted character.
  always @(posedge clk) begin
    char_rec_t exp_rec;
    if (rst) begin
      pending_chars.delete();
      char_count = '0;
      fail_count = 0;
      chars_seen = 0;
    end else begin
      if (in_valid && in_ready) begin
        render_number(opcode_t'(opcode), value);
      end
      if (out_valid && out_ready) begin
        chars_seen = chars_seen + 1;
        if (pending_chars.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected character 0x%02h last=%0b count=%0d", $realtime,
                     char_code, last_char, total_chars);
          end
        end else begin
          exp_rec = pending_chars.pop_front();
          if (char_code !== exp_rec.code || last_char !== exp_rec.is_last ||
              total_chars !== exp_rec.count) begin
            fail_count = fail_count + 1;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: expected char 0x%02h last=%0b count=%0d", $realtime,
                       exp_rec.code, exp_rec.is_last, exp_rec.count);
              $display("%0t:   got    char 0x%02h last=%0b count=%0d", $realtime,
                       char_code, last_char, total_chars);
            end
          end
        end
      end
    end
    chars_left = pending_chars.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Top of the formatter testbench: clock, reset, number stimulus, output
// stalls, watchdog and verdict. Depends on itaf_pkg, tb_checker and the core.
module tb_top;
  import itaf_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 60;
  localparam int RANDOM_ITEMS  = 248;
  localparam int DRAIN_CYCLES  = 80;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         opcode = OP_SDEC;
  logic [31:0]        value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHAR_W-1:0]  char_code;
  logic               last_char;
  logic [COUNT_W-1:0] total_chars;

  int fail_count;
  int chars_left;
  int chars_seen;
  int items_sent = 0;
  int idle_cycles = 0;
  bit steady_sender = 1'b0;

  always #1 clk = ~clk;

  integer_to_ascii_formatter_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_code  (char_code),
    .last_char  (last_char),
    .total_chars(total_chars)
  );

  tb_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_code  (char_code),
    .last_char  (last_char),
    .total_chars(total_chars),
    .fail_count (fail_count),
    .chars_left (chars_left),
    .chars_seen (chars_seen)
  );

  // Idle stretch length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one number and returns at the edge where it is taken.
  task automatic send_item(input opcode_t op, input logic [31:0] num);
    int gap;
    gap = steady_sender ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= num;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent = items_sent + 1;
  endtask

  // Random numbers biased toward digit-count boundaries and sign edges.
  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    int k;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 15);
      2: begin
        p = 32'd1 << $urandom_range(0, 31);
        return $urandom_range(0, 1) ? p - 32'd1 : p;
      end
      3: begin
        p = 32'd1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 32'd10;
        return p + 32'($urandom_range(0, 2)) - 32'd1;
      end
      4: return {1'b1, 31'($urandom)};
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // Main stimulus: reset, directed corners, random numbers, drain, verdict.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero and all ones in every format, then sign boundaries and digit-count edges.
    send_item(OP_SDEC, 32'h0000_0000);
    send_item(OP_UDEC, 32'h0000_0000);
    send_item(OP_HEXL, 32'h0000_0000);
    send_item(OP_HEXU, 32'h0000_0000);
    send_item(OP_SDEC, 32'hFFFF_FFFF);
    send_item(OP_UDEC, 32'hFFFF_FFFF);
    send_item(OP_HEXL, 32'hFFFF_FFFF);
    send_item(OP_HEXU, 32'hFFFF_FFFF);
    send_item(OP_SDEC, 32'h8000_0000);
    send_item(OP_SDEC, 32'h7FFF_FFFF);
    send_item(OP_UDEC, 32'h8000_0000);
    send_item(OP_SDEC, 32'd1);
    send_item(OP_UDEC, 32'd9);
    send_item(OP_UDEC, 32'd10);
    send_item(OP_SDEC, 32'hFFFF_FFF6);
    send_item(OP_UDEC, 32'd1_000_000_000);
    send_item(OP_UDEC, 32'd999_999_999);
    send_item(OP_HEXL, 32'hDEAD_BEEF);
    send_item(OP_HEXU, 32'hDEAD_BEEF);
    send_item(OP_HEXL, 32'h0ABC_DEF0);
    send_item(OP_HEXU, 32'h0000_0010);
    send_item(OP_HEXL, 32'h1000_0000);

    // Random formats and values, with a stretch of back-to-back offers.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady_sender = (i >= 120 && i < 160);
      send_item(opcode_t'($urandom_range(0, 3)), pick_value());
    end
    in_valid <= 1'b0;

    // Let the checker queue the last number before waiting for the drain.
    @(posedge clk);
    while (chars_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d numbers in four formats with zero, all-ones and sign corners.",
             items_sent);
    $display("Checked %0d characters under random stalls and one %0d-cycle output hold.",
             chars_seen, HOLD_CYCLES);
    if (fail_count == 0 && chars_left == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Output side: random stalls, quiet stretches, and one long hold-off
  // while the sender keeps offering numbers.
  initial begin
    int stall_left;
    int cycle_no;
    bit hold_done;
    stall_left = 0;
    cycle_no = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      cycle_no = cycle_no + 1;
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if ((cycle_no / 500) % 4 != 1 && $urandom_range(0, 7) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
